>>> src/xysh_pkg.sv
// Package with the lattice constants, payload types and fixed-point helpers.
`default_nettype none
package xysh_pkg;
	localparam int SideBits  = 5;
	localparam int Side      = 1 << SideBits;
	localparam int CellBits  = 2 * SideBits;
	localparam int AngleBits = 16;
	localparam int InvTBits  = 24;
	localparam logic [InvTBits-1:0] InvTReset = 24'd409600;
	localparam int LogiSteps = 24;

	typedef logic [AngleBits-1:0] angle_t;
	typedef logic [CellBits-1:0]  cell_t;

	typedef enum logic {
		OP_TRIAL = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [SideBits-1:0] site_x;
		logic [SideBits-1:0] site_y;
		angle_t              proposed_angle;
		logic [15:0]         accept_draw;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		angle_t             angle_now;
		logic signed [15:0] chirality;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_CTR,
		ST_RD_N0,
		ST_RD_N1,
		ST_RD_N2,
		ST_RD_N3,
		ST_SUM,
		ST_MUL,
		ST_DECIDE,
		ST_OUT
	} state_t;

	function automatic logic [15:0] logi_tab(input logic [4:0] i);
		logic [15:0] v;
		begin
			case (i)
				5'd0: v = 16'd32768;  5'd1: v = 16'd24743;  5'd2: v = 16'd17626;
				5'd3: v = 16'd11955;  5'd4: v = 16'd7812;   5'd5: v = 16'd4971;
				5'd6: v = 16'd3108;   5'd7: v = 16'd1921;   5'd8: v = 16'd1179;
				5'd9: v = 16'd720;    5'd10: v = 16'd439;   5'd11: v = 16'd267;
				5'd12: v = 16'd162;   5'd13: v = 16'd98;    5'd14: v = 16'd60;
				5'd15: v = 16'd36;    5'd16: v = 16'd22;    5'd17: v = 16'd13;
				5'd18: v = 16'd8;     5'd19: v = 16'd5;     5'd20: v = 16'd3;
				5'd21: v = 16'd2;     5'd22: v = 16'd1;     5'd23: v = 16'd1;
				default: v = 16'd0;
			endcase
			return v;
		end
	endfunction
endpackage
`default_nettype wire

>>> src/xysh_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface xysh_in_if;
	logic              valid;
	logic              ready;
	xysh_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface xysh_out_if;
	logic               valid;
	logic               ready;
	xysh_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/xysh_sine.sv
// Pipelined Q15 sine of a 16-bit phase, polynomial on the quarter wave.
`default_nettype none
module xysh_sine (
	input  wire logic                   clk,
	input  wire logic [15:0]            phase,
	output logic signed [16:0]          sine_s3
);
	import xysh_pkg::*;

	logic [14:0] x_c;
	logic [28:0] sq_c;
	logic [14:0] x_s1;
	logic [15:0] x2_s1;
	logic        neg_s1;
	logic [30:0] x3_c;
	logic [15:0] x3_s2;
	logic [15:0] x2_s2;
	logic [14:0] x_s2;
	logic        neg_s2;
	logic [31:0] x5_c;
	logic [36:0] poly_c;
	logic [22:0] v_c;
	logic [15:0] mag_c;

	always_comb begin
		x_c  = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
		sq_c = 29'(x_c) * 29'(x_c);
	end

	always_ff @(posedge clk) begin
		x_s1   <= x_c;
		x2_s1  <= 16'(sq_c >> 14);
		neg_s1 <= phase[15];
	end

	assign x3_c = 31'(x2_s1) * 31'(x_s1);

	always_ff @(posedge clk) begin
		x_s2   <= x_s1;
		x2_s2  <= x2_s1;
		x3_s2  <= 16'(x3_c >> 14);
		neg_s2 <= neg_s1;
	end

	always_comb begin
		x5_c   = 32'(x3_s2) * 32'(x2_s2);
		poly_c = 37'd51472 * 37'(x_s2) + 37'd2470 * 37'(x5_c >> 14)
		         - 37'd21174 * 37'(x3_s2);
		v_c    = 23'(poly_c >> 14);
		mag_c  = (v_c > 23'd32767) ? 16'd32767 : v_c[15:0];
	end

	always_ff @(posedge clk) begin
		sine_s3 <= neg_s2 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	end
endmodule
`default_nettype wire

>>> src/xy_spin_heat_bath_lattice.sv
// Top level: heat-bath trials and chirality queries on a 32x32 XY spin lattice.
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   op, site_x, site_y, proposed_angle, accept_draw
//  out_ch    out  valid/ready   accepted, angle_now, chirality
//  cfg       in   cfg_we        cfg_data: inverse_temperature
//
// An item runs through reads on the single-port memory, eight (query: four) sine
// issues and the wait for their results from the sine pipeline, a multiply, a
// decide step, the output state and the idle state before the next is accepted.
// After reset a clearing pass writes zero to all 1024 entries, with no item
// accepted. An output stall holds the item in the output state until it is taken.
`default_nettype none
module xy_spin_heat_bath_lattice (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	xysh_in_if.sink                        in_ch,
	xysh_out_if.source                     out_ch,
	input  wire logic                      cfg_we,
	input  wire logic [xysh_pkg::InvTBits-1:0] cfg_data
);
	import xysh_pkg::*;

	angle_t mem [Side*Side];
	angle_t rd_q;
	cell_t  addr_c;
	logic   we_c;
	angle_t wd_c;

	state_t    state_q, state_d;
	in_item_t  item_q;
	logic [InvTBits-1:0] invt_q;
	logic      clr_q;
	cell_t     clr_cnt_q;
	angle_t    ang_q [5];     // centre, then four neighbours (query: three ring corners, then the centre)
	logic [2:0] rcnt_q;
	logic [3:0] scnt_q;       // sine issues
	logic [3:0] rcv_q;        // sine results received
	logic signed [19:0] acc_q;
	logic [42:0] mag_q;
	logic        neg_q;
	out_item_t   res_q;
	logic        ov_q;

	logic [15:0] ph_c;
	logic signed [16:0] sine_s3;
	logic [2:0] valid_pipe_q;
	logic [SideBits-1:0] xr_c, yr_c;
	logic [2:0] ridx_c;
	logic [15:0] prob_c;
	logic        prob_big_c;

	// Address of read number ridx_c relative to the site.
	always_comb begin
		ridx_c = rcnt_q;
		xr_c = item_q.site_x;
		yr_c = item_q.site_y;
		if (item_q.op == OP_TRIAL) begin
			case (ridx_c)
				3'd1: yr_c = item_q.site_y + 1'b1;
				3'd2: xr_c = item_q.site_x + 1'b1;
				3'd3: yr_c = item_q.site_y - 1'b1;
				3'd4: xr_c = item_q.site_x - 1'b1;
				default: ;
			endcase
		end else begin
			case (ridx_c)
				3'd1: yr_c = item_q.site_y + 1'b1;
				3'd2: begin xr_c = item_q.site_x + 1'b1; yr_c = item_q.site_y + 1'b1; end
				3'd3: xr_c = item_q.site_x + 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		we_c   = 1'b0;
		wd_c   = '0;
		addr_c = {yr_c, xr_c};
		if (clr_q) begin
			we_c   = 1'b1;
			addr_c = clr_cnt_q;
		end else if (state_q == ST_DECIDE && item_q.op == OP_TRIAL &&
		             (prob_big_c || prob_c > item_q.accept_draw)) begin
			we_c   = 1'b1;
			wd_c   = item_q.proposed_angle;
			addr_c = {item_q.site_y, item_q.site_x};
		end
	end

	always_ff @(posedge clk) begin
		if (we_c)
			mem[addr_c] <= wd_c;
		rd_q <= mem[addr_c];
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_ch.valid && in_ch.ready) state_d = ST_RD_CTR;
			ST_RD_CTR: if (rcnt_q == 3'd5) state_d = ST_SUM;
			ST_SUM:    if (rcv_q == ((item_q.op == OP_TRIAL) ? 4'd8 : 4'd4)) state_d = ST_MUL;
			ST_MUL:    state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_OUT;
			ST_OUT:    if (!ov_q) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !clr_q && !ov_q;
	assign out_ch.valid = ov_q;
	assign out_ch.data  = res_q;

	// Sine unit input: trial uses cos(n - a) = sin(n - a + quarter).
	always_comb begin
		ph_c = '0;
		if (item_q.op == OP_TRIAL) begin
			ph_c = ang_q[3'(1 + scnt_q[2:1])]
			     - (scnt_q[0] ? item_q.proposed_angle : ang_q[0]) + 16'h4000;
		end else begin
			ph_c = ang_q[3'(scnt_q[1:0] + 2'd1 + 1'b0) == 3'd4 ? 3'd4 : 3'(scnt_q[1:0] + 1)]
			     - ang_q[scnt_q[1:0] == 2'd0 ? 3'd0 : 3'(scnt_q[1:0])];
			case (scnt_q[1:0])
				2'd0: ph_c = ang_q[1] - ang_q[0];
				2'd1: ph_c = ang_q[2] - ang_q[1];
				2'd2: ph_c = ang_q[3] - ang_q[2];
				default: ph_c = ang_q[0] - ang_q[3];
			endcase
		end
	end

	xysh_sine u_sine (
		.clk     (clk),
		.phase   (ph_c),
		.sine_s3 (sine_s3)
	);

	logic issue_c;
	assign issue_c = (state_q == ST_SUM) &&
	                 (scnt_q < ((item_q.op == OP_TRIAL) ? 4'd8 : 4'd4));

	// Logistic from registered |z|.
	logic [4:0]  idx_c;
	logic [15:0] hi_c, lo_c, frac_c, pv_c;
	logic [31:0] prod_c;
	always_comb begin
		idx_c  = 5'(mag_q >> 26);
		hi_c   = logi_tab(idx_c);
		lo_c   = logi_tab(5'(idx_c + 1'b1));
		frac_c = mag_q[25:10];
		prod_c = 32'(hi_c - lo_c) * 32'(frac_c);
		pv_c   = ((mag_q >> 26) >= 43'(LogiSteps)) ? 16'd0 : 16'(hi_c - prod_c[31:16]);
		prob_c = neg_q ? 16'(17'h10000 - 17'(pv_c)) : pv_c;
	end
	assign prob_big_c = neg_q && (pv_c == 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			invt_q       <= InvTReset;
			clr_q        <= 1'b1;
			clr_cnt_q    <= '0;
			rcnt_q       <= '0;
			scnt_q       <= '0;
			rcv_q        <= '0;
			valid_pipe_q <= '0;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				invt_q <= cfg_data;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (&clr_cnt_q)
					clr_q <= 1'b0;
			end
			valid_pipe_q <= {valid_pipe_q[1:0], issue_c};
			if (state_q == ST_IDLE) begin
				rcnt_q <= '0;
				scnt_q <= '0;
				rcv_q  <= '0;
			end
			if (state_q == ST_RD_CTR)
				rcnt_q <= rcnt_q + 1'b1;
			if (issue_c)
				scnt_q <= scnt_q + 1'b1;
			if (valid_pipe_q[2])
				rcv_q <= rcv_q + 1'b1;
			if (state_q == ST_DECIDE)
				ov_q <= 1'b1;
			else if (out_ch.ready)
				ov_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			item_q <= in_ch.data;
		if (state_q == ST_RD_CTR && rcnt_q != 3'd0)
			ang_q[3'(rcnt_q - 1'b1)] <= rd_q;
		if (state_q == ST_IDLE)
			acc_q <= '0;
		else if (valid_pipe_q[2]) begin
			if (item_q.op == OP_QUERY || !rcv_q[0])
				acc_q <= acc_q + 20'(sine_s3);
			else
				acc_q <= acc_q - 20'(sine_s3);
		end
		if (state_q == ST_MUL) begin
			mag_q <= 43'(acc_q[19] ? 20'(-acc_q) : acc_q) * 43'(invt_q);
			neg_q <= acc_q[19] && (invt_q != '0);
		end
		if (state_q == ST_DECIDE) begin
			res_q.accepted  <= (item_q.op == OP_TRIAL) &&
			                   (prob_big_c || prob_c > item_q.accept_draw);
			res_q.angle_now <= ((item_q.op == OP_TRIAL) &&
			                    (prob_big_c || prob_c > item_q.accept_draw))
			                   ? item_q.proposed_angle : ang_q[0];
			res_q.chirality <= (item_q.op == OP_TRIAL) ? 16'sd0
			                   : 16'(($signed(acc_q) + (acc_q[19] ? 20'sd3 : 20'sd0)) >>> 2);
		end
	end

	ast_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
	ast_clear_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ch.ready) else $error("accept during clearing pass");
	ast_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(!clr_q && item_q.op == OP_QUERY && state_q != ST_IDLE) |-> !we_c)
		else $error("query wrote memory");
	ast_result_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q == ST_DECIDE)) else $error("stray result");
endmodule
`default_nettype wire
